@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define SRAG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a property holds at every rising clock edge, reset included.
`define SRAG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ design/srag_pkg.sv @@
package srag_pkg;

   localparam int MAX_DIMS = 8;
   localparam int DIM_W    = $clog2(MAX_DIMS);

   localparam int SIZE_W   = 16;
   localparam int STEP_W   = 32;
   localparam int INDEX_W  = 40;
   localparam int EXT_W    = 32;
   localparam int OFFSET_W = 48;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_RANK         = 3'd0;
   localparam logic [2:0] CSR_REPEAT_AXIS  = 3'd1;
   localparam logic [2:0] CSR_REPEAT_COUNT = 3'd2;
   localparam logic [2:0] CSR_SOURCE_BASE  = 3'd3;
   localparam logic [2:0] CSR_DEST_BASE    = 3'd4;

   // Request kinds carried in req_tuser.
   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   // One dimension descriptor.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [STEP_W-1:0] source_step;
      logic [STEP_W-1:0] dest_step;
   } desc_type;

   // Control of one descriptor cell.
   typedef struct packed {
      logic load;
      logic rotate;
   } cell_ctrl_type;

endpackage

@@ design/strided_repeat_address_generator.sv @@
// Channel   Direction  Accepted when              Contents
// req_*     in         req_tvalid & req_tready    descriptor load or index translate
// rsp_*     out        rsp_tvalid & rsp_tready    source and destination offsets
// csr_*     in         csr_valid & csr_ready      register index and write data
//
// A descriptor load writes its cell and the block stays ready for the next
// transaction. A translate turns the ring to bring the highest dimension in
// use to the head, then per dimension divides, divides again on the repeat
// axis, multiplies and accumulates, then hands the result over; the divider,
// one bit per cycle, serves every dimension in turn. Zero extents skip the walk.
// Reset is synchronous and active high; it clears the control state, the axis
// and the bases, sets rank and repeat count to one, and leaves the descriptor
// cells undefined until loaded. A stalled result waits in the output register;
// the block still takes one more translate, which waits finished until the
// register frees, and the input stalls behind it.
`include "assert_macros.svh"

module strided_repeat_address_generator (
   input  logic          clock,
   input  logic          reset,
   // Request channel.
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata from bit 0: dim_slot[2:0], source_size[18:3], source_step[50:19],
   // dest_step[82:51], linear_index[122:83], zero fill [127:123].
   input  logic [127:0]  req_tdata,
   // tuser: opcode.
   input  logic          req_tuser,
   // Response channel.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata from bit 0: source_offset[47:0], dest_offset[95:48].
   output logic [95:0]   rsp_tdata,
   // tuser: out_of_range.
   output logic          rsp_tuser,
   // Configuration write channel.
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int DW = srag_pkg::DIM_W;
   localparam int OW = srag_pkg::OFFSET_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_EXT,
      ST_DIVX,
      ST_DIVR,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [3:0]  rank_ff, rank_in;
   logic [2:0]  axis_ff, axis_in;
   logic [15:0] rep_ff, rep_in;
   logic [31:0] sbase_ff, sbase_in;
   logic [31:0] dbase_ff, dbase_in;

   // Sequencer state.
   state_type                    state_ff, state_in;
   logic [DW-1:0]                rot_cnt_ff, rot_cnt_in;
   logic [DW-1:0]                dim_ff, dim_in;
   logic [DW-1:0]                ring_pos_ff, ring_pos_in;
   logic [srag_pkg::INDEX_W-1:0] rem_ff, rem_in;
   logic [srag_pkg::EXT_W-1:0]   idx_ff, idx_in;
   logic [srag_pkg::EXT_W-1:0]   sidx_ff, sidx_in;
   logic [OW-1:0]                prod_s_ff, prod_s_in;
   logic [OW-1:0]                prod_d_ff, prod_d_in;
   logic [OW-1:0]                soff_ff, soff_in;
   logic [OW-1:0]                doff_ff, doff_in;
   logic                         oor_ff, oor_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic                         rsp_oor_ff, rsp_oor_in;
   logic [OW-1:0]                rsp_src_ff, rsp_src_in;
   logic [OW-1:0]                rsp_dst_ff, rsp_dst_in;

   // Descriptor ring.
   srag_pkg::cell_ctrl_type ctrl [srag_pkg::MAX_DIMS];
   srag_pkg::desc_type      desc [srag_pkg::MAX_DIMS];
   srag_pkg::desc_type      load_desc;
   srag_pkg::desc_type      head;
   logic                    rotate;

   // Divider hookup.
   logic                         div_start;
   logic [srag_pkg::INDEX_W-1:0] div_dividend;
   logic [srag_pkg::EXT_W-1:0]   div_divisor;
   logic                         div_done;
   logic [srag_pkg::INDEX_W-1:0] div_quot;
   logic [srag_pkg::EXT_W-1:0]   div_rem;

   logic                         req_fire;
   logic [3:0]                   nd;
   logic                         any_zero;
   logic [srag_pkg::EXT_W-1:0]   ext;
   logic signed [64:0]           mul_s;
   logic signed [64:0]           mul_d;
   logic                         out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign load_desc.size        = req_tdata[18:3];
   assign load_desc.source_step = req_tdata[50:19];
   assign load_desc.dest_step   = req_tdata[82:51];

   // The head of the ring is the last cell. Rotation moves every descriptor
   // one cell toward the head, so the head walks down the dimensions.
   assign head = desc[srag_pkg::MAX_DIMS-1];

   for (genvar i = 0; i < srag_pkg::MAX_DIMS; i++) begin : g_cell
      assign ctrl[i].load   = req_fire && (req_tuser == srag_pkg::OP_LOAD)
                              && (req_tdata[DW-1:0] == DW'(i));
      assign ctrl[i].rotate = rotate;
      srag_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .load_desc (load_desc),
         .prev_desc (desc[(i + srag_pkg::MAX_DIMS - 1) % srag_pkg::MAX_DIMS]),
         .desc      (desc[i])
      );
   end

   srag_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Rank zero counts as one dimension, and ranks above the cell count saturate.
   always_comb begin
      if (rank_ff == 4'd0) begin
         nd = 4'd1;
      end else if (rank_ff > 4'(srag_pkg::MAX_DIMS)) begin
         nd = 4'(srag_pkg::MAX_DIMS);
      end else begin
         nd = rank_ff;
      end
   end

   // With the ring at rest, cell i holds dimension i. Any zero extent in use
   // makes the total zero, so every index is then out of range.
   always_comb begin
      any_zero = 1'b0;
      for (int i = 0; i < srag_pkg::MAX_DIMS; i++) begin
         if ((4'(i) < nd) && (desc[i].size == '0)) begin
            any_zero = 1'b1;
         end
      end
   end

   // Output extent of the head dimension; the repeat axis grows by the count.
   assign ext = 32'(head.size) *
                ((dim_ff == axis_ff) ? 32'(rep_ff) : 32'd1);

   // Unsigned index times signed stride; the low 48 bits are all that count.
   assign mul_s = $signed({1'b0, sidx_ff}) * $signed(head.source_step);
   assign mul_d = $signed({1'b0, idx_ff}) * $signed(head.dest_step);

   always_comb begin
      rank_in  = rank_ff;
      axis_in  = axis_ff;
      rep_in   = rep_ff;
      sbase_in = sbase_ff;
      dbase_in = dbase_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            srag_pkg::CSR_RANK:         rank_in  = csr_data[3:0];
            srag_pkg::CSR_REPEAT_AXIS:  axis_in  = csr_data[2:0];
            srag_pkg::CSR_REPEAT_COUNT: rep_in   = (csr_data[15:0] == '0) ?
                                                   16'd1 : csr_data[15:0];
            srag_pkg::CSR_SOURCE_BASE:  sbase_in = csr_data;
            srag_pkg::CSR_DEST_BASE:    dbase_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      rot_cnt_in    = rot_cnt_ff;
      dim_in        = dim_ff;
      ring_pos_in   = ring_pos_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      sidx_in       = sidx_ff;
      prod_s_in     = prod_s_ff;
      prod_d_in     = prod_d_ff;
      soff_in       = soff_ff;
      doff_in       = doff_ff;
      oor_in        = oor_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_oor_in    = rsp_oor_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      rotate        = 1'b0;
      div_start     = 1'b0;
      div_dividend  = rem_ff;
      div_divisor   = ext;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == srag_pkg::OP_TRANSLATE)) begin
               rem_in     = req_tdata[122:83];
               soff_in    = OW'(sbase_ff);
               doff_in    = OW'(dbase_ff);
               rot_cnt_in = DW'(4'(srag_pkg::MAX_DIMS) - nd);
               dim_in     = DW'(nd - 4'd1);
               oor_in     = any_zero;
               state_in   = any_zero ? ST_DONE : ST_ROT;
            end
         end
         ST_ROT: begin
            // Bring the highest dimension in use to the head.
            if (rot_cnt_ff == '0) begin
               state_in = ST_EXT;
            end else begin
               rotate      = 1'b1;
               ring_pos_in = ring_pos_ff + 1'b1;
               rot_cnt_in  = rot_cnt_ff - 1'b1;
            end
         end
         ST_EXT: begin
            div_start = 1'b1;
            state_in  = ST_DIVX;
         end
         ST_DIVX: begin
            if (div_done) begin
               rem_in  = div_quot;
               idx_in  = div_rem;
               sidx_in = div_rem;
               if (dim_ff == axis_ff) begin
                  div_start    = 1'b1;
                  div_dividend = srag_pkg::INDEX_W'(div_rem);
                  div_divisor  = srag_pkg::EXT_W'(rep_ff);
                  state_in     = ST_DIVR;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIVR: begin
            if (div_done) begin
               sidx_in  = div_quot[srag_pkg::EXT_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_s_in = mul_s[OW-1:0];
            prod_d_in = mul_d[OW-1:0];
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            soff_in     = soff_ff + prod_s_ff;
            doff_in     = doff_ff + prod_d_ff;
            rotate      = 1'b1;
            ring_pos_in = ring_pos_ff + 1'b1;
            if (dim_ff == '0) begin
               // A quotient left after the outermost dimension means the
               // index is at or beyond the total element count.
               oor_in   = (rem_ff != '0);
               state_in = ST_DONE;
            end else begin
               dim_in   = dim_ff - 1'b1;
               state_in = ST_EXT;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_oor_in    = oor_ff;
               rsp_src_in    = oor_ff ? '0 : soff_ff;
               rsp_dst_in    = oor_ff ? '0 : doff_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rot_cnt_ff    <= '0;
         dim_ff        <= '0;
         ring_pos_ff   <= '0;
         oor_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         rank_ff       <= 4'd1;
         axis_ff       <= '0;
         rep_ff        <= 16'd1;
         sbase_ff      <= '0;
         dbase_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rot_cnt_ff    <= rot_cnt_in;
         dim_ff        <= dim_in;
         ring_pos_ff   <= ring_pos_in;
         oor_ff        <= oor_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rank_ff       <= rank_in;
         axis_ff       <= axis_in;
         rep_ff        <= rep_in;
         sbase_ff      <= sbase_in;
         dbase_ff      <= dbase_in;
      end
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      sidx_ff    <= sidx_in;
      prod_s_ff  <= prod_s_in;
      prod_d_ff  <= prod_d_in;
      soff_ff    <= soff_in;
      doff_ff    <= doff_in;
      rsp_oor_ff <= rsp_oor_in;
      rsp_src_ff <= rsp_src_in;
      rsp_dst_ff <= rsp_dst_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_oor_ff;
   assign rsp_tdata  = {rsp_dst_ff, rsp_src_ff};

   `SRAG_ASSERT(a_oor_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0), "out-of-range result carries nonzero offsets")
   `SRAG_ASSERT(a_translate_busy, (req_fire && req_tuser == srag_pkg::OP_TRANSLATE) |=> !req_tready, "translate did not make the block busy")
   `SRAG_ASSERT(a_ring_home, (state_ff == ST_IDLE) |-> (ring_pos_ff == '0), "descriptor ring not at rest when idle")

endmodule

@@ design/srag_cell.sv @@
// One descriptor cell of the ring. It is either written directly or takes
// the descriptor of its upstream neighbor when the ring rotates.
module srag_cell (
   input  logic                   clock,
   input  srag_pkg::cell_ctrl_type ctrl,
   input  srag_pkg::desc_type      load_desc,
   input  srag_pkg::desc_type      prev_desc,
   output srag_pkg::desc_type      desc
);

   srag_pkg::desc_type desc_ff;
   srag_pkg::desc_type desc_in;

   always_comb begin
      desc_in = desc_ff;
      if (ctrl.load) begin
         desc_in = load_desc;
      end else if (ctrl.rotate) begin
         desc_in = prev_desc;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   assign desc = desc_ff;

endmodule

@@ design/srag_div.sv @@
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle. Results are valid in the
// cycle that done is high and hold until the next start.
module srag_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srag_pkg::INDEX_W-1:0]  dividend,
   input  logic [srag_pkg::EXT_W-1:0]    divisor,
   output logic                          done,
   output logic [srag_pkg::INDEX_W-1:0]  quotient,
   output logic [srag_pkg::EXT_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(srag_pkg::INDEX_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(srag_pkg::INDEX_W - 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [srag_pkg::INDEX_W-1:0] quot_ff, quot_in;
   logic [srag_pkg::EXT_W-1:0]   acc_ff, acc_in;
   logic [srag_pkg::EXT_W-1:0]   dvs_ff, dvs_in;
   logic [srag_pkg::EXT_W:0]     trial;
   logic [srag_pkg::EXT_W:0]     diff;

   always_comb begin
      trial   = {acc_ff, quot_ff[srag_pkg::INDEX_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      acc_in  = acc_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         acc_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // A borrow means the trial remainder is below the divisor.
         if (diff[srag_pkg::EXT_W]) begin
            acc_in = trial[srag_pkg::EXT_W-1:0];
         end else begin
            acc_in = diff[srag_pkg::EXT_W-1:0];
         end
         quot_in = {quot_ff[srag_pkg::INDEX_W-2:0], ~diff[srag_pkg::EXT_W]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      acc_ff  <= acc_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = acc_ff;

   `SRAG_ASSERT(a_start_when_free, start |-> !busy_ff, "divider started while busy")
   `SRAG_ASSERT(a_done_ends_busy, done_ff |-> !busy_ff, "divider done while still busy")
   `SRAG_ASSERT(a_cnt_range, busy_ff |-> (cnt_ff <= LAST), "divider step count out of range")

endmodule
